// ===== design/per_source_rate_meter_assert.svh =====
// Assertion macros used by the rate meter checker.
// Needs clk and arst_n in the scope of each use.
`ifndef PER_SOURCE_RATE_METER_ASSERT_SVH
`define PER_SOURCE_RATE_METER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define RSM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rsm_pkg.sv =====
// Package for the per-source rate meter: beat, slot and result types, constants.
// No dependencies; imported by every module of the block.
package rsm_pkg;

	localparam int ADDR_W    = 32;
	localparam int LEN_W     = 16;
	localparam int SEC_W     = 32;
	localparam int BYTES_W   = 40;
	localparam int PACKETS_W = 20;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;

	localparam logic [BYTES_W-1:0]   BYTES_MAX   = {BYTES_W{1'b1}};
	localparam logic [PACKETS_W-1:0] PACKETS_MAX = {PACKETS_W{1'b1}};

	localparam logic [31:0]          MAX_BYTES_RST   = 32'd1000000;
	localparam logic [PACKETS_W-1:0] MAX_PACKETS_RST = 20'd1000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKETS = 4'd1;

	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [LEN_W-1:0]  len;
		logic [SEC_W-1:0]  sec;
	} rsm_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    addr;
		logic [SEC_W-1:0]     second;
		logic [BYTES_W-1:0]   bytes;
		logic [PACKETS_W-1:0] packets;
	} rsm_slot_t;

	typedef struct packed {
		logic                 byte_alarm;
		logic                 packet_alarm;
		logic [BYTES_W-1:0]   bytes;
		logic [PACKETS_W-1:0] packets;
		logic                 table_full;
	} rsm_result_t;

	typedef struct packed {
		logic [31:0]          max_bytes;
		logic [PACKETS_W-1:0] max_packets;
	} rsm_cfg_t;

	// front-to-back queue handshake
	typedef struct packed {
		logic      valid;
		rsm_item_t item;
	} rsm_queue_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} rsm_state_t;

endpackage

// ===== design/rsm_front.sv =====
// Front end of the rate meter: input beat intake and a two-entry queue.
// Depends on rsm_pkg.
module rsm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rsm_pkg::ADDR_W-1:0]    source_address,
	input  logic [rsm_pkg::LEN_W-1:0]     packet_bytes,
	input  logic [rsm_pkg::SEC_W-1:0]     current_second,
	output rsm_pkg::rsm_queue_t           queue,
	input  logic                          pop
);
	import rsm_pkg::*;

	rsm_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != 2'd0);

	assign queue.valid = (count_q != 2'd0);
	assign queue.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{src: source_address, len: packet_bytes, sec: current_second};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/rsm_back.sv =====
// Back end of the rate meter: slot memory walk, update, and result register.
// Depends on rsm_pkg.
module rsm_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsm_pkg::rsm_queue_t   queue,
	output logic                  pop,
	input  rsm_pkg::rsm_cfg_t     cfg,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rsm_pkg::rsm_result_t  result
);
	import rsm_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_ENTRIES);

	rsm_slot_t mem [TABLE_ENTRIES];

	rsm_state_t           state_q, state_d;
	rsm_item_t            item_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     iss_idx_q;
	logic                 rv_s1;
	logic [IDX_W-1:0]     ri_s1;
	rsm_slot_t            rd_data_s1;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [BYTES_W-1:0]   hit_bytes_q;
	logic [PACKETS_W-1:0] hit_packets_q;
	logic                 empty_q;
	logic [IDX_W-1:0]     empty_idx_q;
	logic                 out_valid_q;
	rsm_result_t          res_q;

	logic                 issue;
	logic                 live;
	logic                 found_now;
	logic                 scan_done;
	logic                 out_free;
	logic                 finish;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	rsm_slot_t            wr_data;
	logic                 fill_inc;
	logic                 full;
	logic [BYTES_W:0]     sum;
	logic [BYTES_W-1:0]   new_bytes;
	logic [PACKETS_W-1:0] new_packets;
	rsm_result_t          res_d;

	// scan datapath
	assign live      = rv_s1 && (rd_data_s1.second == item_q.sec);
	assign found_now = live && (rd_data_s1.addr == item_q.src);
	assign out_free  = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (queue.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop       = 1'b0;
		issue     = 1'b0;
		scan_done = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop = queue.valid;
			end
			ST_SCAN: begin
				issue     = (iss_idx_q < fill_q);
				scan_done = found_now || !issue;
			end
			ST_DECIDE: begin
				finish = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// update decision for the packet in hand
	always_comb begin
		sum         = {1'b0, hit_bytes_q} + {{(BYTES_W + 1 - LEN_W){1'b0}}, item_q.len};
		new_bytes   = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
		new_packets = (hit_packets_q == PACKETS_MAX) ? PACKETS_MAX
		                                             : hit_packets_q + PACKETS_W'(1);
		wr_idx   = hit_idx_q;
		wr_data  = '{addr: item_q.src, second: item_q.sec, bytes: new_bytes,
		             packets: new_packets};
		fill_inc = 1'b0;
		full     = 1'b0;
		priority if (hit_q) begin
			wr_idx = hit_idx_q;
		end else if (empty_q) begin
			wr_idx              = empty_idx_q;
			new_bytes           = {{(BYTES_W - LEN_W){1'b0}}, item_q.len};
			new_packets         = PACKETS_W'(1);
			wr_data.bytes       = new_bytes;
			wr_data.packets     = new_packets;
		end else if (fill_q < FILL_MAX) begin
			wr_idx              = fill_q[IDX_W-1:0];
			fill_inc            = 1'b1;
			new_bytes           = {{(BYTES_W - LEN_W){1'b0}}, item_q.len};
			new_packets         = PACKETS_W'(1);
			wr_data.bytes       = new_bytes;
			wr_data.packets     = new_packets;
		end else begin
			full = 1'b1;
		end
		wr_en = finish && !full;

		if (full) begin
			res_d = '{byte_alarm: 1'b0, packet_alarm: 1'b0, bytes: '0, packets: '0,
			          table_full: 1'b1};
		end else begin
			res_d = '{byte_alarm: (new_bytes > {{(BYTES_W - 32){1'b0}}, cfg.max_bytes}),
			          packet_alarm: (new_packets > cfg.max_packets),
			          bytes: new_bytes, packets: new_packets, table_full: 1'b0};
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[iss_idx_q[IDX_W-1:0]];
			ri_s1      <= iss_idx_q[IDX_W-1:0];
		end
	end

	// working item and scan results
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= queue.item;
		end
		if (found_now && state_q == ST_SCAN) begin
			hit_idx_q     <= ri_s1;
			hit_bytes_q   <= rd_data_s1.bytes;
			hit_packets_q <= rd_data_s1.packets;
		end
		if (state_q == ST_SCAN && rv_s1 && !live && !empty_q) begin
			empty_idx_q <= ri_s1;
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			iss_idx_q   <= '0;
			rv_s1       <= 1'b0;
			hit_q       <= 1'b0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= issue && !scan_done;
			if (pop) begin
				iss_idx_q <= '0;
				hit_q     <= 1'b0;
				empty_q   <= 1'b0;
			end else if (issue) begin
				iss_idx_q <= iss_idx_q + CNT_W'(1);
			end
			if (state_q == ST_SCAN && found_now) begin
				hit_q <= 1'b1;
			end
			if (state_q == ST_SCAN && rv_s1 && !live) begin
				empty_q <= 1'b1;
			end
			if (wr_en && fill_inc) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

// ===== design/per_source_rate_meter.sv =====
// Per-source rate meter. Each result beat follows a walk over the claimed slots that ends
// early on a match; fill, the number of slots ever claimed, is at most TABLE_ENTRIES. The
// back end takes one beat at a time from the queue, walking the slot memory at one read
// per cycle.
// Reset (arst_n, async low): thresholds to 1000000 bytes / 1000 packets, queue and output
// empty, slot fill count to zero; the slot memory itself is not cleared and needs no pass.
// Depends on rsm_pkg, rsm_front, rsm_back.
module per_source_rate_meter #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input beats
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rsm_pkg::ADDR_W-1:0]       source_address,
	input  logic [rsm_pkg::LEN_W-1:0]        packet_bytes,
	input  logic [rsm_pkg::SEC_W-1:0]        current_second,
	// result beats
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             byte_alarm,
	output logic                             packet_alarm,
	output logic [rsm_pkg::BYTES_W-1:0]      bytes_this_second,
	output logic [rsm_pkg::PACKETS_W-1:0]    packets_this_second,
	output logic                             table_full,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rsm_pkg::CFG_DAT_W-1:0]    cfg_data
);
	import rsm_pkg::*;

	rsm_cfg_t    cfg_q;
	rsm_queue_t  queue;
	logic        pop;
	rsm_result_t result;

	// Threshold registers; unknown indexes are dropped. Writes land any time; the user must
	// write only while idle (not enforced), so an item in flight never sees a threshold change.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_bytes   <= MAX_BYTES_RST;
			cfg_q.max_packets <= MAX_PACKETS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MAX_BYTES) begin
				cfg_q.max_bytes <= cfg_data;
			end else if (cfg_index == CFG_MAX_PACKETS) begin
				cfg_q.max_packets <= cfg_data[PACKETS_W-1:0];
			end
		end
	end

	// Front: packs the beat and buffers up to two items, so intake keeps going while
	// the back end walks the table or holds a result the downstream has stalled.
	rsm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.source_address (source_address),
		.packet_bytes   (packet_bytes),
		.current_second (current_second),
		.queue          (queue),
		.pop            (pop)
	);

	// Back: walks the claimed slots in index order (the memory read is registered, so each
	// compare comes in the cycle after its read), stops early on a live match, then writes
	// the updated or newly claimed slot if there is room, and loads the output register.
	// Claimed slots always form a prefix of the table: a never-used slot is only taken
	// when every lower slot is live, so a fill count stands in for per-slot valid bits.
	rsm_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.queue     (queue),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign byte_alarm          = result.byte_alarm;
	assign packet_alarm        = result.packet_alarm;
	assign bytes_this_second   = result.bytes;
	assign packets_this_second = result.packets;
	assign table_full          = result.table_full;

endmodule

// ===== design/rsm_checker.sv =====
// Port-level checker for the per-source rate meter, bound to the top level.
// Depends on rsm_pkg and per_source_rate_meter_assert.svh.
`include "per_source_rate_meter_assert.svh"

module rsm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          byte_alarm,
	input logic                          packet_alarm,
	input logic [rsm_pkg::BYTES_W-1:0]   bytes_this_second,
	input logic [rsm_pkg::PACKETS_W-1:0] packets_this_second,
	input logic                          table_full
);
	import rsm_pkg::*;

	// dropped packet carries nothing
	`RSM_ASSERT_IMP(a_full_zero, out_valid && table_full,
		!byte_alarm && !packet_alarm && bytes_this_second == '0 && packets_this_second == '0,
		"table_full result with nonzero fields")

	// a counted packet has at least itself
	`RSM_ASSERT_IMP(a_counted_nonzero, out_valid && !table_full,
		packets_this_second != '0, "counted result with zero packets")

	// a byte alarm, whatever the threshold, implies a counted result with a nonzero byte total
	`RSM_ASSERT_IMP(a_alarm_bytes, out_valid && byte_alarm,
		!table_full && bytes_this_second != '0, "byte alarm without bytes")

	`RSM_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(bytes_this_second) && $stable(packets_this_second),
		"stalled result changed")

endmodule

bind per_source_rate_meter rsm_checker u_rsm_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (out_valid),
	.out_stall           (out_stall),
	.byte_alarm          (byte_alarm),
	.packet_alarm        (packet_alarm),
	.bytes_this_second   (bytes_this_second),
	.packets_this_second (packets_this_second),
	.table_full          (table_full)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for per_source_rate_meter: a scoreboard class predicts every result beat.
// Depends on rsm_pkg and the per_source_rate_meter RTL only.
module tb_top;
	import rsm_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 4;
	// Slowest legal run: ~1300 beats at most, each with the longest idle gap at the sender,
	// a full table walk and the longest stall burst at the receiver, plus the long
	// hold-off. The limit is several times that total.
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_CYCLES   = 900;
	localparam int END_SLACK     = 2 * (TABLE_ENTRIES + 4);
	localparam int PHASES        = 7;
	localparam int PHASE_BEATS   = 105;
	localparam int PRESSURE_PHASE = 2;
	localparam int POOL_SIZE     = 12;
	localparam int SEC_MEMORY    = 4;
	localparam int REPORT_LINES  = 40;
	localparam int CFG_SPARE_FIRST = int'(CFG_MAX_PACKETS) + 1;
	localparam int CFG_LAST_IDX  = (1 << CFG_IDX_W) - 1;

	// how the sources of one second are drawn
	typedef enum {
		MIX_HEAVY,	// a handful of sources, many beats each: drives the alarms
		MIX_SPREAD,	// pool sources plus random noise addresses
		MIX_FLOOD	// more fresh sources than slots: runs the table full
	} traffic_mix_t;

	// ------------------------------------------------------------------
	// Scoreboard: own copy of thresholds and slot table, queue of totals due
	// ------------------------------------------------------------------
	class meter_scoreboard;
		logic [31:0]          max_bytes;
		logic [PACKETS_W-1:0] max_packets;
		rsm_slot_t            slots[TABLE_ENTRIES];
		bit                   claimed[TABLE_ENTRIES];
		rsm_result_t          due_totals[$];
		int                   fails;
		int                   beats_seen;

		function new();
			max_bytes   = MAX_BYTES_RST;
			max_packets = MAX_PACKETS_RST;
			foreach (claimed[i]) claimed[i] = 1'b0;
			fails      = 0;
			beats_seen = 0;
		endfunction

		function int pending();
			return due_totals.size();
		endfunction

		task report(string msg);
			fails++;
			if (fails <= REPORT_LINES)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		function void note_threshold(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			if (idx == CFG_MAX_BYTES)
				max_bytes = val;
			else if (idx == CFG_MAX_PACKETS)
				max_packets = val[PACKETS_W-1:0];
			// any other index: write has no effect
		endfunction

		// Walk the slots in index order: first live slot of this source wins,
		// else the first slot that is unclaimed or tagged with another second.
		function void note_packet(rsm_item_t it);
			int                 hit;
			int                 vacant;
			logic [BYTES_W:0]   sum;
			rsm_result_t        r;
			hit    = -1;
			vacant = -1;
			r      = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (claimed[i] && slots[i].second == it.sec) begin
					if (hit < 0 && slots[i].addr == it.src)
						hit = i;
				end else if (vacant < 0) begin
					vacant = i;
				end
			end
			if (hit < 0 && vacant < 0) begin
				r.table_full = 1'b1;
			end else begin
				if (hit >= 0) begin
					sum = {1'b0, slots[hit].bytes} + (BYTES_W + 1)'(it.len);
					slots[hit].bytes = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
					if (slots[hit].packets != PACKETS_MAX)
						slots[hit].packets = slots[hit].packets + PACKETS_W'(1);
				end else begin
					hit = vacant;
					claimed[hit]       = 1'b1;
					slots[hit].addr    = it.src;
					slots[hit].second  = it.sec;
					slots[hit].bytes   = BYTES_W'(it.len);
					slots[hit].packets = PACKETS_W'(1);
				end
				r.bytes        = slots[hit].bytes;
				r.packets      = slots[hit].packets;
				r.byte_alarm   = slots[hit].bytes > BYTES_W'(max_bytes);
				r.packet_alarm = slots[hit].packets > max_packets;
			end
			due_totals = {due_totals, r};
		endfunction

		task check_result(rsm_result_t got);
			rsm_result_t want;
			if (due_totals.size() == 0) begin
				report($sformatf("result beat with none due: bytes %0d packets %0d full %0b",
					got.bytes, got.packets, got.table_full));
				return;
			end
			want = due_totals[0];
			due_totals.delete(0);
			if (got.table_full !== want.table_full)
				report($sformatf("beat %0d table_full %b, want %b", beats_seen,
					got.table_full, want.table_full));
			if (got.bytes !== want.bytes)
				report($sformatf("beat %0d bytes_this_second %0d, want %0d", beats_seen,
					got.bytes, want.bytes));
			if (got.packets !== want.packets)
				report($sformatf("beat %0d packets_this_second %0d, want %0d", beats_seen,
					got.packets, want.packets));
			if (got.byte_alarm !== want.byte_alarm)
				report($sformatf("beat %0d byte_alarm %b, want %b", beats_seen,
					got.byte_alarm, want.byte_alarm));
			if (got.packet_alarm !== want.packet_alarm)
				report($sformatf("beat %0d packet_alarm %b, want %b", beats_seen,
					got.packet_alarm, want.packet_alarm));
			beats_seen++;
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------
	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid;
	logic                 in_stall;
	logic [ADDR_W-1:0]    source_address;
	logic [LEN_W-1:0]     packet_bytes;
	logic [SEC_W-1:0]     current_second;
	logic                 out_valid;
	logic                 out_stall;
	logic                 byte_alarm;
	logic                 packet_alarm;
	logic [BYTES_W-1:0]   bytes_this_second;
	logic [PACKETS_W-1:0] packets_this_second;
	logic                 table_full;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	meter_scoreboard sb = new();

	// stimulus knobs shared between processes
	bit                in_idle_on  = 1'b1;
	bit                rx_idle_on  = 1'b1;
	bit                hold_off_go = 1'b0;
	logic [ADDR_W-1:0] src_pool[POOL_SIZE];
	logic [SEC_W-1:0]  recent_secs[SEC_MEMORY];
	logic [SEC_W-1:0]  cur_sec;
	int                cycles;

	per_source_rate_meter #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.source_address     (source_address),
		.packet_bytes       (packet_bytes),
		.current_second     (current_second),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.byte_alarm         (byte_alarm),
		.packet_alarm       (packet_alarm),
		.bytes_this_second  (bytes_this_second),
		.packets_this_second(packets_this_second),
		.table_full         (table_full),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: any hang ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// Result beats are taken at the rising edge where valid is up and we do not stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(rsm_result_t'{byte_alarm, packet_alarm, bytes_this_second,
				packets_this_second, table_full});
	end

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// block backs up and has to stall its input side.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------

	// Zero and all-ones lengths show up often; short ones keep byte totals low.
	function automatic logic [LEN_W-1:0] rand_len();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return LEN_W'($urandom_range(0, 63));
			default: return LEN_W'($urandom());
		endcase
	endfunction

	// One input beat. Valid stays up across back-to-back beats; a gap lowers it
	// at a falling edge and raises it again at a later one.
	task automatic send_packet(rsm_item_t it);
		int gap;
		gap = 0;
		if (in_idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 18);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		source_address <= it.src;
		packet_bytes   <= it.len;
		current_second <= it.sec;
		do @(posedge clk); while (in_stall);
		sb.note_packet(it);
	endtask

	// Drop valid and wait until every due result beat has come back.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.note_threshold(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic, one second's worth at a time. Seconds mostly tick on,
	// sometimes jump, repeat, or go back to a recent one whose slots may still
	// be tagged live.
	task automatic run_phase(int quota);
		int           sent;
		int           n;
		int           pick;
		int           heavy;
		traffic_mix_t mix;
		sent = 0;
		foreach (src_pool[i]) src_pool[i] = $urandom();
		case ($urandom_range(0, 3))
			0:       src_pool[0] = '0;
			1:       src_pool[0] = '1;
			default: ;
		endcase
		while (sent < quota) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				cur_sec = cur_sec + 1'b1;
			else if (pick < 8)
				cur_sec = $urandom();
			else if (pick == 8)
				cur_sec = recent_secs[$urandom_range(0, SEC_MEMORY - 1)];
			recent_secs[sent % SEC_MEMORY] = cur_sec;

			pick = $urandom_range(0, 19);
			mix  = (pick < 8) ? MIX_HEAVY : (pick < 17) ? MIX_SPREAD : MIX_FLOOD;
			case (mix)
				MIX_HEAVY: begin
					heavy = $urandom_range(1, 4);
					n     = $urandom_range(5, 40);
					repeat (n)
						send_packet(rsm_item_t'{src_pool[$urandom_range(0, heavy - 1)],
							rand_len(), cur_sec});
				end
				MIX_SPREAD: begin
					n = $urandom_range(10, 50);
					repeat (n)
						send_packet(rsm_item_t'{($urandom_range(0, 9) < 7) ?
							src_pool[$urandom_range(0, POOL_SIZE - 1)] : ADDR_W'($urandom()),
							rand_len(), cur_sec});
				end
				MIX_FLOOD: begin
					// a few known sources, then more fresh ones than there are
					// slots, then known ones again: any that already hold a slot must still hit
					n = TABLE_ENTRIES + $urandom_range(1, 6);
					repeat (3)
						send_packet(rsm_item_t'{src_pool[$urandom_range(0, 2)], rand_len(), cur_sec});
					repeat (n)
						send_packet(rsm_item_t'{ADDR_W'($urandom()), rand_len(), cur_sec});
					repeat (3)
						send_packet(rsm_item_t'{src_pool[$urandom_range(0, 2)], rand_len(), cur_sec});
					n += 6;
				end
			endcase
			sent += n;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int p;
		in_valid       = 1'b0;
		source_address = '0;
		packet_bytes   = '0;
		current_second = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cycles         = 0;
		cur_sec        = $urandom();
		foreach (recent_secs[i]) recent_secs[i] = cur_sec;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset thresholds. Field extremes, a hit, a stale slot
		// reclaimed for a new second, then the old second coming back.
		send_packet(rsm_item_t'{32'h0000_0000, 16'h0000, 32'h0000_0000});
		send_packet(rsm_item_t'{32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000});
		send_packet(rsm_item_t'{32'h0000_0000, 16'hFFFF, 32'h0000_0000});
		send_packet(rsm_item_t'{32'h0000_0000, 16'h0000, 32'hFFFF_FFFF});
		send_packet(rsm_item_t'{32'hFFFF_FFFF, 16'h0001, 32'h0000_0000});
		send_packet(rsm_item_t'{32'h0000_0000, 16'h0005, 32'h0000_0000});
		send_packet(rsm_item_t'{32'hA5A5_A5A5, 16'h5A5A, 32'h5A5A_5A5A});
		send_packet(rsm_item_t'{32'h5A5A_5A5A, 16'hA5A5, 32'hA5A5_A5A5});

		// Zero thresholds: the first beat already trips the packet alarm; a
		// zero-length beat adds a packet but no bytes. Spare index is ignored.
		settle();
		write_reg(CFG_MAX_BYTES, '0);
		write_reg(CFG_MAX_PACKETS, '0);
		write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_LAST_IDX)), $urandom());
		send_packet(rsm_item_t'{32'h0000_0001, 16'h0000, 32'h0000_0001});
		send_packet(rsm_item_t'{32'h0000_0001, 16'h0001, 32'h0000_0001});

		// Alarms are strictly above: equal to the threshold stays quiet.
		settle();
		write_reg(CFG_MAX_BYTES, 32'd1000);
		write_reg(CFG_MAX_PACKETS, {12'hFFF, 20'd3});
		send_packet(rsm_item_t'{32'h0000_0002, 16'd500, 32'h0000_0002});
		send_packet(rsm_item_t'{32'h0000_0002, 16'd500, 32'h0000_0002});
		send_packet(rsm_item_t'{32'h0000_0002, 16'd0,   32'h0000_0002});
		send_packet(rsm_item_t'{32'h0000_0002, 16'd1,   32'h0000_0002});

		// Top thresholds: nothing reachable can trip them.
		settle();
		write_reg(CFG_MAX_BYTES, '1);
		write_reg(CFG_MAX_PACKETS, '1);
		send_packet(rsm_item_t'{32'h0000_0002, 16'hFFFF, 32'h0000_0002});
		send_packet(rsm_item_t'{32'h0000_0002, 16'hFFFF, 32'h0000_0002});

		// Random phases, each with its own threshold setting.
		for (p = 0; p < PHASES; p++) begin
			settle();
			if (p == PHASES - 1) begin
				// final stretch runs flat out on both sides
				in_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			case (p % 5)
				0: begin
					write_reg(CFG_MAX_BYTES, $urandom_range(0, 300000));
					write_reg(CFG_MAX_PACKETS, {12'($urandom()), 20'($urandom_range(0, 25))});
				end
				1: begin
					write_reg(CFG_MAX_BYTES, '0);
					write_reg(CFG_MAX_PACKETS, '0);
				end
				2: begin
					write_reg(CFG_MAX_BYTES, '1);
					write_reg(CFG_MAX_PACKETS, {12'($urandom()), PACKETS_MAX});
				end
				3: begin
					write_reg(CFG_MAX_PACKETS, $urandom());
					write_reg(CFG_MAX_BYTES, $urandom());
				end
				default: begin
					write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);
					write_reg(CFG_MAX_PACKETS, 32'(MAX_PACKETS_RST));
				end
			endcase
			if (p % 2 == 1)
				write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_LAST_IDX)), $urandom());
			if (p == PRESSURE_PHASE)
				hold_off_go = 1'b1;
			run_phase(PHASE_BEATS);
		end

		// Drain, then wait END_SLACK, longer than a full table walk, to show
		// any stray result beat.
		settle();
		repeat (END_SLACK) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d result beats never arrived", sb.pending()));
		if (sb.fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
